@@ sv/csm_pkg.sv @@
// Shared types, constants and helpers for the CSR sparse matrix-vector block.
// No dependencies; imported by every module of the block and by its checker.
`default_nettype none

package csm_pkg;

  // Vector store geometry
  localparam int VECTOR_DEPTH = 1024;
  localparam int VEC_AW       = $clog2(VECTOR_DEPTH);

  // Field widths fixed by the item format
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int ACC_W = 64;
  localparam int ROW_W = 10;
  localparam int RC_W  = 11;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_ROW_COUNT   = '0;
  localparam logic [RC_W-1:0]   ROW_COUNT_RESET = 11'd1;

  // Input modes
  localparam logic [1:0] MODE_XWRITE  = 2'd0;
  localparam logic [1:0] MODE_NONZERO = 2'd1;
  localparam logic [1:0] MODE_EMPTY   = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // Queue command opcodes
  localparam logic [1:0] OP_XWRITE = 2'd0;
  localparam logic [1:0] OP_MAC    = 2'd1;
  localparam logic [1:0] OP_CLOSE  = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]              mode;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    row_end;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [ACC_W-1:0] y_value;
    logic                    saturated;
    logic                    last_row;
  } out_item_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [VEC_AW-1:0]       addr;
    logic signed [VAL_W-1:0] value;
    logic                    row_end;
    logic                    in_range;
  } cmd_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic                    ovf;
  } sat_sum_t;

  // Two's complement add clamped to the signed accumulator range
  function automatic sat_sum_t sat_add(input logic signed [ACC_W-1:0] a,
                                       input logic signed [ACC_W-1:0] b);
    sat_sum_t                r;
    logic signed [ACC_W-1:0] s;
    s     = a + b;
    r.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
    r.sum = r.ovf ? (a[ACC_W-1] ? ACC_MIN : ACC_MAX) : s;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/csr_sparse_matvec.sv @@
// Top level of the streaming CSR sparse matrix-vector multiply, y = A*x.
// Depends on csm_pkg, csm_front, csm_queue and csm_back.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_item_t  (mode, index, value, row_end)
//   out_     output     out_valid/out_ready  out_item_t (row_index, y_value, ...)
//   cfg_     APB slave  psel/penable/pready  row_count at byte address 0
//
// One item per clock sustained when not stalled; a result's closing beat is written to
// the queue, then goes through store read, multiply and accumulate into the result
// register. The accumulator feedback add sets the rate.
// Reset is synchronous, active low; the vector store is not cleared.
// in_ready drops only when the four-entry queue is full; the pipe stalls
// only when a result is due and the output register is still occupied.
`default_nettype none

module csr_sparse_matvec import csm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic            q_full;
  logic            push;
  cmd_t            push_cmd;
  logic            pop;
  cmd_t            pop_cmd;
  logic            q_valid;
  logic [RC_W-1:0] row_count_r;
  logic            cfg_hit;
  logic            cfg_wr;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_ROW_COUNT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? CFG_DW'(row_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RESET;
    end else if (cfg_wr) begin
      row_count_r <= cfg_pwdata[RC_W-1:0];
    end
  end

  csm_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  csm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_valid)
  );

  csm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .pop       (pop),
    .row_count (row_count_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ sv/csm_front.sv @@
// Front end: takes input beats, decodes the mode and pushes commands.
// Depends on csm_pkg.
`default_nettype none

module csm_front import csm_pkg::*; (
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          push,
  output cmd_t          push_cmd
);

  logic in_range;
  logic keep;

  // Index check against the store depth
  assign in_range = (32'(in_data.index) < 32'(VECTOR_DEPTH));

  // Classify: out-of-range writes and the unused mode are dropped here
  always_comb begin
    push_cmd.addr     = VEC_AW'(in_data.index);
    push_cmd.value    = in_data.value;
    push_cmd.in_range = in_range;
    push_cmd.row_end  = 1'b0;
    push_cmd.op       = OP_XWRITE;
    keep              = 1'b0;
    case (in_data.mode)
      MODE_XWRITE: begin
        push_cmd.op = OP_XWRITE;
        keep        = in_range;
      end
      MODE_NONZERO: begin
        push_cmd.op      = OP_MAC;
        push_cmd.row_end = in_data.row_end;
        keep             = 1'b1;
      end
      MODE_EMPTY: begin
        push_cmd.op = OP_CLOSE;
        keep        = 1'b1;
      end
      MODE_NONE: begin
        keep = 1'b0;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && keep;

endmodule

`default_nettype wire

@@ sv/csm_queue.sv @@
// Short command FIFO decoupling the front end from the datapath.
// Depends on csm_pkg.
`default_nettype none

module csm_queue import csm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      not_empty
);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]    count_r, count_nxt;

  assign full      = (count_r == (Q_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ sv/csm_back.sv @@
// Back end: vector store, multiplier, saturating accumulator, result register.
// Depends on csm_pkg.
`default_nettype none

module csm_back import csm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire cmd_t            q_cmd,
  output logic                 pop,
  input  wire logic [RC_W-1:0] row_count,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output out_item_t            out_data
);

  // Vector store and read stage
  logic [VAL_W-1:0]        vec_mem_r [VECTOR_DEPTH];
  logic [VAL_W-1:0]        rd_data_r;
  logic                    s2_valid_r;
  logic [1:0]              s2_op_r;
  logic signed [VAL_W-1:0] s2_coef_r;
  logic                    s2_end_r;
  logic                    s2_in_range_r;

  // Multiply stage
  logic signed [VAL_W-1:0] x_val;
  logic signed [ACC_W-1:0] prod_nxt;
  logic                    s3_valid_r;
  logic [1:0]              s3_op_r;
  logic                    s3_end_r;
  logic signed [ACC_W-1:0] prod_r;

  // Accumulate stage
  logic signed [ACC_W-1:0] acc_r;
  logic                    ovf_r;
  logic [ROW_W-1:0]        row_ctr_r, row_ctr_nxt;
  sat_sum_t                step;
  logic                    emit;
  logic                    stall;
  logic                    last;
  logic                    out_valid_r;
  out_item_t               out_data_r, out_data_nxt;

  // Hold the whole pipe only when a result has nowhere to go
  assign emit  = s3_valid_r && ((s3_op_r == OP_CLOSE) || s3_end_r);
  assign stall = emit && out_valid_r && !out_ready;
  assign pop   = q_valid && !stall;

  // Store write and read, one command a beat unless the pipe stalls
  always_ff @(posedge clk) begin
    if (pop && (q_cmd.op == OP_XWRITE)) begin
      vec_mem_r[q_cmd.addr] <= q_cmd.value;
    end
    if (pop && (q_cmd.op == OP_MAC)) begin
      rd_data_r <= vec_mem_r[q_cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_op_r       <= q_cmd.op;
      s2_coef_r     <= q_cmd.value;
      s2_end_r      <= q_cmd.row_end;
      s2_in_range_r <= q_cmd.in_range;
    end
  end

  // Q16.16 x Q16.16 gives an exact Q32.32 product
  assign x_val    = s2_in_range_r ? $signed(rd_data_r) : '0;
  assign prod_nxt = s2_coef_r * x_val;

  always_ff @(posedge clk) begin
    if (!stall) begin
      prod_r   <= (s2_op_r == OP_MAC) ? prod_nxt : '0;
      s3_op_r  <= s2_op_r;
      s3_end_r <= (s2_op_r == OP_MAC) && s2_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (!stall) begin
      s2_valid_r <= pop && (q_cmd.op != OP_XWRITE);
      s3_valid_r <= s2_valid_r;
    end
  end

  // Accumulate; a close with no product adds zero
  assign step = sat_add(acc_r, prod_r);
  assign last = (row_count != '0) && ({1'b0, row_ctr_r} == (row_count - 1'b1));

  always_comb begin
    row_ctr_nxt            = last ? '0 : row_ctr_r + 1'b1;
    out_data_nxt.row_index = row_ctr_r;
    out_data_nxt.y_value   = step.sum;
    out_data_nxt.saturated = ovf_r || step.ovf;
    out_data_nxt.last_row  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      row_ctr_r <= '0;
    end else if (s3_valid_r && !stall) begin
      if (emit) begin
        acc_r     <= '0;
        ovf_r     <= 1'b0;
        row_ctr_r <= row_ctr_nxt;
      end else begin
        acc_r <= step.sum;
        ovf_r <= ovf_r || step.ovf;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && !stall) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && !stall) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ sv/csm_checker.sv @@
// Port-level checker for csr_sparse_matvec, attached by the bind below.
// Depends on csm_pkg and the top level's port list.
`default_nettype none

module csm_checker import csm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  logic             closer_in;
  logic             out_beat;
  logic [4:0]       pend_r, pend_nxt;
  logic [ROW_W-1:0] exp_row_r, exp_row_nxt;

  // Beats that must produce a result, and results still owed
  assign closer_in = in_valid && in_ready &&
                     ((in_data.mode == MODE_EMPTY) ||
                      ((in_data.mode == MODE_NONZERO) && in_data.row_end));
  assign out_beat  = out_valid && out_ready;

  always_comb begin
    pend_nxt    = pend_r + 5'(closer_in) - 5'(out_beat);
    exp_row_nxt = exp_row_r;
    if (out_beat) begin
      exp_row_nxt = out_data.last_row ? '0 : exp_row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      exp_row_r <= '0;
    end else begin
      pend_r    <= pend_nxt;
      exp_row_r <= exp_row_nxt;
    end
  end

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Rows are numbered in close order and restart after the last row
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.row_index == exp_row_r)
    else $error("row index out of sequence");

  // No result without a row-closing beat before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a closing beat");

endmodule

bind csr_sparse_matvec csm_checker u_csm_checker (.*);

`default_nettype wire
